// ===== hw/rtl/multi_mode_pid_controller_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-mode PID controller
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_PID_CONTROLLER_TOP_ASSERT_SVH
`define MULTI_MODE_PID_CONTROLLER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMPID_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMPID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/mmpid_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-mode PID controller package
// Register indexes, mode codes and the configuration record.
// ----------------------------------------------------------------------------
package mmpid_pkg;

   // Configuration port geometry
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // Field widths fixed by the register map
   localparam int MODE_W  = 2;
   localparam int GAIN_W  = 20;
   localparam int LIMIT_W = 15;
   localparam int OUT_W   = 32;
   localparam int OUT_FRAC = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT  = 3'd4;

   // Control laws
   localparam logic [MODE_W-1:0] MODE_POS = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INC = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PD  = 2'd2;

   // Reset values
   localparam logic [MODE_W-1:0]  RST_MODE   = MODE_POS;
   localparam logic [GAIN_W-1:0]  RST_GAIN_P = 20'd197;
   localparam logic [GAIN_W-1:0]  RST_GAIN_I = 20'd328;
   localparam logic [GAIN_W-1:0]  RST_GAIN_D = 20'd0;
   localparam logic [LIMIT_W-1:0] RST_LIMIT  = 15'd1000;

   // Configuration record handed from the register block to the datapath
   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [LIMIT_W-1:0] output_limit;
   } cfg_type;

endpackage

// ===== hw/rtl/multi_mode_pid_controller_top.sv =====
// ----------------------------------------------------------------------------
// Multi-mode PID controller
// Positional PID, incremental PID or clamped PD on setpoint/measured pairs.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while the result side does
// not stall and returns one drive value for each: the first register holds
// the error terms and updates the controller state, the second holds the
// three gain products, and the third holds the rounded, saturated or clamped
// drive. Back-pressure fills the empty stages first, so up to three
// transactions may be in flight. Configuration must be written by the user
// only while the block is idle; the block itself does not enforce this.
module multi_mode_pid_controller_top
   import mmpid_pkg::*;
#(
   parameter int DATA_WIDTH     = 16,
   parameter int GAIN_FRAC_BITS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   // Request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [DATA_WIDTH-1:0] setpoint, [2*DATA_WIDTH-1:DATA_WIDTH] measured, zero pad
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   // Response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] drive
   output logic [OUT_W-1:0]      rsp_tdata,
   // [0] saturated
   output logic                  rsp_tuser,
   // Configuration port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   `include "multi_mode_pid_controller_top_assert.svh"

   // Widths derived from the data width
   localparam int EW    = DATA_WIDTH + 1;          // error
   localparam int TW    = EW + 2;                  // difference terms
   localparam int SW    = 32;                      // error sum
   localparam int GW    = GAIN_W + 1;              // gain as signed operand
   localparam int PA_W  = GW + TW;
   localparam int PB_W  = GW + SW;
   localparam int PC_W  = GW + TW;
   localparam int ACC_W = PB_W + 2;
   localparam int SHR   = (GAIN_FRAC_BITS >= OUT_FRAC) ? GAIN_FRAC_BITS - OUT_FRAC : 0;
   localparam int SHL   = (GAIN_FRAC_BITS <  OUT_FRAC) ? OUT_FRAC - GAIN_FRAC_BITS : 0;
   localparam int Q_W   = ACC_W + SHL;

   cfg_type cfg;

   mmpid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // ---------------------------------------------------------------------
   // Handshake and stage valid bits
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_ready, s2_ready, s1_ready;
   logic req_acc, s1_adv, s2_adv;

   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign req_acc   = req_tvalid && s1_ready;
   assign s1_adv    = s1_valid_ff && s2_ready;
   assign s2_adv    = s2_valid_ff && out_ready;

   // Each stage fills from the one before and drains into the one after.
   always_comb begin
      s1_valid_in  = req_acc || (s1_valid_ff && !s2_ready);
      s2_valid_in  = s1_adv  || (s2_valid_ff && !out_ready);
      rsp_valid_in = s2_adv  || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: errors, difference terms and controller state
   // ---------------------------------------------------------------------
   logic signed [DATA_WIDTH-1:0] sp, ms;
   logic signed [EW-1:0] err_fwd, err_rev, err;
   logic signed [EW-1:0] prev_error_ff, prev_error_in;
   logic signed [EW-1:0] prev_prev_error_ff, prev_prev_error_in;
   logic signed [SW-1:0] error_sum_ff, error_sum_in;
   logic signed [SW:0]   sum_wide;
   logic signed [SW-1:0] sum_sat;
   logic                 sum_ovf;
   logic signed [TW-1:0] err_t, prev_t, pprev_t;
   logic signed [TW-1:0] term_a, term_c;
   logic signed [SW-1:0] term_b;
   logic                 sat_s1;
   logic signed [TW-1:0] s1_a_ff, s1_c_ff;
   logic signed [SW-1:0] s1_b_ff;
   logic                 s1_sat_ff;

   assign sp = signed'(req_tdata[DATA_WIDTH-1:0]);
   assign ms = signed'(req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
   assign err_fwd = {sp[DATA_WIDTH-1], sp} - {ms[DATA_WIDTH-1], ms};
   assign err_rev = {ms[DATA_WIDTH-1], ms} - {sp[DATA_WIDTH-1], sp};
   assign err     = (cfg.mode == MODE_PD) ? err_rev : err_fwd;

   assign err_t   = {{(TW-EW){err[EW-1]}}, err};
   assign prev_t  = {{(TW-EW){prev_error_ff[EW-1]}}, prev_error_ff};
   assign pprev_t = {{(TW-EW){prev_prev_error_ff[EW-1]}}, prev_prev_error_ff};

   // Saturating error sum at the 32-bit bounds.
   assign sum_wide = {error_sum_ff[SW-1], error_sum_ff}
                   + {{(SW+1-EW){err[EW-1]}}, err};
   assign sum_ovf  = sum_wide[SW] != sum_wide[SW-1];
   assign sum_sat  = !sum_ovf ? sum_wide[SW-1:0]
                   : (sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});

   // Operands of the three gains for the selected law.
   always_comb begin
      term_a = '0;
      term_b = '0;
      term_c = '0;
      sat_s1 = 1'b0;
      case (cfg.mode)
         MODE_POS: begin
            term_a = err_t;
            term_b = sum_sat;
            term_c = prev_t - err_t;
            sat_s1 = sum_ovf;
         end
         MODE_INC: begin
            term_a = err_t - prev_t;
            term_b = {{(SW-EW){err[EW-1]}}, err};
            term_c = err_t - (prev_t <<< 1) + pprev_t;
         end
         MODE_PD: begin
            term_a = prev_t;
            term_c = err_t - prev_t;
         end
         default: begin
            term_a = '0;
         end
      endcase
   end

   // State moves on with each accepted transaction, as its law asks.
   always_comb begin
      prev_error_in      = prev_error_ff;
      prev_prev_error_in = prev_prev_error_ff;
      error_sum_in       = error_sum_ff;
      if (req_acc) begin
         case (cfg.mode)
            MODE_POS: begin
               error_sum_in  = sum_sat;
               prev_error_in = err;
            end
            MODE_INC: begin
               prev_prev_error_in = prev_error_ff;
               prev_error_in      = err;
            end
            MODE_PD: begin
               prev_error_in = err;
            end
            default: begin
               prev_error_in = prev_error_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff      <= '0;
         prev_prev_error_ff <= '0;
         error_sum_ff       <= '0;
      end else begin
         prev_error_ff      <= prev_error_in;
         prev_prev_error_ff <= prev_prev_error_in;
         error_sum_ff       <= error_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_a_ff   <= term_a;
         s1_b_ff   <= term_b;
         s1_c_ff   <= term_c;
         s1_sat_ff <= sat_s1;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: gain products
   // ---------------------------------------------------------------------
   logic signed [GW-1:0]   kp, ki, kd;
   logic signed [PA_W-1:0] pa_in, s2_pa_ff;
   logic signed [PB_W-1:0] pb_in, s2_pb_ff;
   logic signed [PC_W-1:0] pc_in, s2_pc_ff;
   logic                   s2_sat_ff;

   assign kp = signed'({1'b0, cfg.gain_p});
   assign ki = signed'({1'b0, cfg.gain_i});
   assign kd = signed'({1'b0, cfg.gain_d});

   assign pa_in = kp * s1_a_ff;
   assign pb_in = ki * s1_b_ff;
   assign pc_in = kd * s1_c_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_pa_ff  <= pa_in;
         s2_pb_ff  <= pb_in;
         s2_pc_ff  <= pc_in;
         s2_sat_ff <= s1_sat_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: sum, scale to Q16.16, saturate or clamp
   // ---------------------------------------------------------------------
   logic signed [ACC_W-1:0] acc;
   logic signed [Q_W-1:0]   q_val, lim_q, lim_neg;
   logic                    q_fits;
   logic [OUT_W-1:0]        drive_in, drive_ff;
   logic                    sat_in, sat_ff;

   assign acc = ACC_W'(s2_pa_ff) + ACC_W'(s2_pb_ff) + ACC_W'(s2_pc_ff);
   // Shift right floors; shift left is exact.
   assign q_val   = (Q_W'(acc) <<< SHL) >>> SHR;
   assign q_fits  = (&q_val[Q_W-1:OUT_W-1]) || !(|q_val[Q_W-1:OUT_W-1]);
   assign lim_q   = signed'(Q_W'({cfg.output_limit, {OUT_FRAC{1'b0}}}));
   assign lim_neg = -lim_q;

   always_comb begin
      drive_in = q_val[OUT_W-1:0];
      sat_in   = s2_sat_ff;
      case (cfg.mode)
         MODE_PD: begin
            if (q_val > lim_q) begin
               drive_in = lim_q[OUT_W-1:0];
               sat_in   = 1'b1;
            end else if (q_val < lim_neg) begin
               drive_in = lim_neg[OUT_W-1:0];
               sat_in   = 1'b1;
            end
         end
         default: begin
            if (!q_fits) begin
               drive_in = q_val[Q_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                       : {1'b0, {(OUT_W-1){1'b1}}};
               sat_in   = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         drive_ff <= drive_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = drive_ff;
   assign rsp_tuser  = sat_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `MMPID_ASSERT_NOW(a_empty_ready, clock, reset,
      !s1_valid_ff && !s2_valid_ff && !rsp_valid_ff, req_tready,
      "empty pipeline refused a transaction")
   `MMPID_ASSERT_NEXT(a_s1_hold, clock, reset,
      s1_valid_ff && !s2_ready, s1_valid_ff,
      "stalled operand stage lost its transaction")
   `MMPID_ASSERT_NEXT(a_pprev_only_inc, clock, reset,
      !(req_acc && cfg.mode == MODE_INC), $stable(prev_prev_error_ff),
      "older error moved outside incremental mode")
   `MMPID_ASSERT_NEXT(a_sum_only_pos, clock, reset,
      !(req_acc && cfg.mode == MODE_POS), $stable(error_sum_ff),
      "error sum moved outside positional mode")

endmodule

// ===== hw/rtl/mmpid_csr.sv =====
// ----------------------------------------------------------------------------
// Multi-mode PID controller register block
// Holds the mode, gain and limit registers written through the plain port.
// ----------------------------------------------------------------------------
module mmpid_csr
   import mmpid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; indexes past the map are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MODE:   cfg_in.mode         = csr_wdata[MODE_W-1:0];
            CSR_GAIN_P: cfg_in.gain_p       = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I: cfg_in.gain_i       = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D: cfg_in.gain_d       = csr_wdata[GAIN_W-1:0];
            CSR_LIMIT:  cfg_in.output_limit = csr_wdata[LIMIT_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= RST_MODE;
         cfg_ff.gain_p       <= RST_GAIN_P;
         cfg_ff.gain_i       <= RST_GAIN_I;
         cfg_ff.gain_d       <= RST_GAIN_D;
         cfg_ff.output_limit <= RST_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== tb/tb_multi_mode_pid_controller_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the multi-mode PID controller
// Drives setpoint/measured pairs through all three control laws and the unused
// mode, predicts every drive value with an independent model of the laws,
// and checks each response transaction in order under random back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_multi_mode_pid_controller_top;
   import mmpid_pkg::*;

   localparam int DW         = 16;
   localparam int EW         = DW + 1;
   localparam int GAIN_FRAC  = 16;
   localparam int REQ_W      = ((2*DW+7)/8)*8;
   localparam int PIPE_DEPTH = 3;
   localparam int LONG_HOLD  = 80;

   localparam int SHIFT_DOWN = (GAIN_FRAC > OUT_FRAC) ? GAIN_FRAC - OUT_FRAC : 0;
   localparam int SHIFT_UP   = (GAIN_FRAC < OUT_FRAC) ? OUT_FRAC - GAIN_FRAC : 0;

   localparam longint S32_HI = 64'sd2147483647;
   localparam longint S32_LO = -64'sd2147483647 - 1;

   // Mode code with no control law behind it
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [DW-1:0] setpoint;
      logic signed [DW-1:0] measured;
   } pid_pair_t;

   typedef struct packed {
      logic signed [OUT_W-1:0] drive;
      logic                    saturated;
   } drive_result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_W-1:0]      rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Controller settings as last written
   logic [MODE_W-1:0]  cfg_mode  = RST_MODE;
   logic [GAIN_W-1:0]  cfg_kp    = RST_GAIN_P;
   logic [GAIN_W-1:0]  cfg_ki    = RST_GAIN_I;
   logic [GAIN_W-1:0]  cfg_kd    = RST_GAIN_D;
   logic [LIMIT_W-1:0] cfg_limit = RST_LIMIT;

   // Controller state mirrored from the laws
   logic signed [DW:0]      last_err  = '0;
   logic signed [DW:0]      older_err = '0;
   logic signed [OUT_W-1:0] err_sum   = '0;

   pid_pair_t     pair_q[$];
   drive_result_t drive_expect_q[$];
   int            mismatch_count = 0;
   bit            req_taken = 1'b0;
   bit            calm = 1'b0;
   int            send_gap = 0;
   int            hold_left = 0;
   int            long_hold_requests = 0;
   int            long_hold_served = 0;
   int            walk_sp = 0;
   int            walk_ms = 0;

   multi_mode_pid_controller_top #(
      .DATA_WIDTH     (DW),
      .GAIN_FRAC_BITS (GAIN_FRAC)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // The run is cut short here if the block stops answering.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic longint clip_s32(input longint v);
      if (v > S32_HI) return S32_HI;
      if (v < S32_LO) return S32_LO;
      return v;
   endfunction

   // Bring the exact gain-product sum to Q16.16; a right shift floors.
   function automatic longint to_q16(input longint v);
      return (v >>> SHIFT_DOWN) <<< SHIFT_UP;
   endfunction

   // Works out the drive for one pair and advances the controller state.
   function automatic drive_result_t pid_law_step(input logic signed [DW-1:0] sp,
                                                  input logic signed [DW-1:0] ms);
      longint        kp, ki, kd, e, sum, acc, q, lim;
      drive_result_t r;
      kp = longint'(cfg_kp);
      ki = longint'(cfg_ki);
      kd = longint'(cfg_kd);
      r.drive = '0;
      r.saturated = 1'b0;
      case (cfg_mode)
         MODE_POS: begin
            e = longint'(sp) - longint'(ms);
            sum = longint'(err_sum) + e;
            if (sum != clip_s32(sum)) r.saturated = 1'b1;
            sum = clip_s32(sum);
            acc = kp * e + ki * sum + kd * (longint'(last_err) - e);
            q = to_q16(acc);
            if (q != clip_s32(q)) r.saturated = 1'b1;
            r.drive = OUT_W'(clip_s32(q));
            err_sum = OUT_W'(sum);
            last_err = EW'(e);
         end
         MODE_INC: begin
            e = longint'(sp) - longint'(ms);
            acc = kp * (e - longint'(last_err)) + ki * e
                + kd * (e - 2 * longint'(last_err) + longint'(older_err));
            q = to_q16(acc);
            if (q != clip_s32(q)) r.saturated = 1'b1;
            r.drive = OUT_W'(clip_s32(q));
            older_err = last_err;
            last_err = EW'(e);
         end
         MODE_PD: begin
            // The error is taken the other way round in this law.
            e = longint'(ms) - longint'(sp);
            lim = longint'(cfg_limit) * 65536;
            acc = kp * longint'(last_err) + kd * (e - longint'(last_err));
            q = to_q16(acc);
            if (q > lim) begin
               q = lim;
               r.saturated = 1'b1;
            end else if (q < -lim) begin
               q = -lim;
               r.saturated = 1'b1;
            end
            r.drive = OUT_W'(q);
            last_err = EW'(e);
         end
         default: begin
            // The unused mode ignores the pair and leaves the state alone.
         end
      endcase
      return r;
   endfunction

   function automatic logic signed [DW-1:0] corner_value();
      case ($urandom_range(0, 4))
         0: return DW'(-32768);
         1: return DW'(-1);
         2: return '0;
         3: return DW'(1);
         default: return DW'(32767);
      endcase
   endfunction

   // Mostly a measured value settling towards a setpoint that jumps now and
   // then, mixed with fully random, small and corner pairs.
   function automatic pid_pair_t random_pair();
      pid_pair_t p;
      case ($urandom_range(0, 9))
         0, 1: begin
            p.setpoint = DW'($urandom);
            p.measured = DW'($urandom);
         end
         2: begin
            p.setpoint = corner_value();
            p.measured = corner_value();
         end
         3: begin
            p.setpoint = DW'(int'($urandom_range(0, 600)) - 300);
            p.measured = DW'(int'($urandom_range(0, 600)) - 300);
         end
         default: begin
            if ($urandom_range(0, 7) == 0) walk_sp = int'($urandom_range(0, 65535)) - 32768;
            walk_ms = walk_ms + (walk_sp - walk_ms) / 4 + int'($urandom_range(0, 40)) - 20;
            if (walk_ms > 32767) walk_ms = 32767;
            if (walk_ms < -32768) walk_ms = -32768;
            p.setpoint = DW'(walk_sp);
            p.measured = DW'(walk_ms);
         end
      endcase
      return p;
   endfunction

   function automatic logic [GAIN_W-1:0] random_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return GAIN_W'($urandom_range(0, 255));
         3: return GAIN_W'($urandom_range(0, 8191));
         4: return GAIN_W'($urandom_range(0, 65536));
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   function automatic logic [LIMIT_W-1:0] random_limit();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return LIMIT_W'($urandom_range(1, 2000));
      endcase
   endfunction

   task automatic push_pair(input int sp, input int ms);
      pid_pair_t p;
      p.setpoint = DW'(sp);
      p.measured = DW'(ms);
      pair_q.push_back(p);
   endtask

   // Holds the stimulus until every pending pair is accepted and answered.
   task automatic wait_idle();
      while (pair_q.size() != 0 || req_tvalid || drive_expect_q.size() != 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic load_config(input logic [MODE_W-1:0]  mode,
                              input logic [GAIN_W-1:0]  kp,
                              input logic [GAIN_W-1:0]  ki,
                              input logic [GAIN_W-1:0]  kd,
                              input logic [LIMIT_W-1:0] lim);
      wait_idle();
      write_csr(CSR_MODE,   CSR_DATA_W'(mode));
      write_csr(CSR_GAIN_P, CSR_DATA_W'(kp));
      write_csr(CSR_GAIN_I, CSR_DATA_W'(ki));
      write_csr(CSR_GAIN_D, CSR_DATA_W'(kd));
      write_csr(CSR_LIMIT,  CSR_DATA_W'(lim));
      cfg_mode  = mode;
      cfg_kp    = kp;
      cfg_ki    = ki;
      cfg_kd    = kd;
      cfg_limit = lim;
   endtask

   // Request driver: offers the pending pairs, with short random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            req_tvalid <= 1'b0;
            send_gap   <= send_gap - 1;
         end else if (pair_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            req_tvalid <= 1'b0;
            send_gap   <= $urandom_range(0, 2);
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_W'({pair_q[0].measured, pair_q[0].setpoint});
            pair_q.delete(0);
         end
      end
   end

   // Response ready: short random stalls, and a long hold when asked for.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (long_hold_served != long_hold_requests) begin
         rsp_tready <= 1'b0;
         hold_left  <= LONG_HOLD - 1;
         long_hold_served = long_hold_requests;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predicts on each accepted request and checks each response.
   always @(posedge clock) begin
      drive_result_t want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (req_taken)
            drive_expect_q.push_back(pid_law_step(req_tdata[DW-1:0], req_tdata[2*DW-1:DW]));
         if (rsp_tvalid && rsp_tready) begin
            if (drive_expect_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected transaction, drive %0d saturated %0b",
                        $time, $signed(rsp_tdata), rsp_tuser);
            end else begin
               want = drive_expect_q.pop_front();
               if (rsp_tdata !== want.drive || rsp_tuser !== want.saturated) begin
                  mismatch_count++;
                  $display("%0t: expected drive %0d saturated %0b, got drive %0d saturated %0b",
                           $time, want.drive, want.saturated, $signed(rsp_tdata), rsp_tuser);
               end
            end
         end
      end
   end

   // Stimulus sequence
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Positional law at reset settings: field extremes and unit errors.
      push_pair(0, 0);
      push_pair(32767, -32768);
      push_pair(-32768, 32767);
      push_pair(32767, 32767);
      push_pair(-32768, -32768);
      push_pair(1, 0);
      push_pair(0, 1);
      push_pair(-1, -1);

      // Incremental law with full gains: largest second differences.
      load_config(MODE_INC, '1, '1, '1, RST_LIMIT);
      push_pair(32767, -32768);
      push_pair(-32768, 32767);
      push_pair(0, 0);

      // PD with a zero limit: an exact zero passes, anything else clamps.
      load_config(MODE_PD, '1, '1, '1, '0);
      push_pair(0, 0);
      push_pair(-32768, 32767);
      push_pair(32767, -32768);

      // PD with unit derivative gain: drive exactly at the limit is not
      // clamped, one step beyond it is.
      load_config(MODE_PD, '0, '0, GAIN_W'(65536), LIMIT_W'(1));
      push_pair(32767, -32767);
      push_pair(32767, -32766);
      push_pair(32767, -32767);
      push_pair(32767, -32765);

      // Unused mode: pairs are ignored.
      load_config(MODE_UNUSED, '1, '1, '1, '1);
      push_pair(32767, -32768);
      push_pair(-32768, 32767);
      push_pair(5, 3);

      // Random settings and pairs; one phase holds the response side off.
      for (int ph = 0; ph < 12; ph++) begin
         load_config((ph == 10) ? MODE_UNUSED : MODE_W'(ph % 3),
                     random_gain(), random_gain(), random_gain(), random_limit());
         if (ph == 4) long_hold_requests++;
         walk_sp = int'($urandom_range(0, 65535)) - 32768;
         walk_ms = int'($urandom_range(0, 65535)) - 32768;
         repeat (25) pair_q.push_back(random_pair());
      end

      // Positional law again on the error sum built up so far.
      load_config(MODE_POS, random_gain(), '0, random_gain(), random_limit());
      repeat (25) pair_q.push_back(random_pair());
      load_config(MODE_POS, random_gain(), random_gain(), random_gain(), random_limit());
      repeat (25) pair_q.push_back(random_pair());

      // Closing stretch without idling on either side.
      for (int ph = 0; ph < 3; ph++) begin
         load_config(MODE_W'(ph), random_gain(), random_gain(), random_gain(),
                     random_limit());
         calm = 1'b1;
         repeat (20) pair_q.push_back(random_pair());
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mmpid_pkg.sv
hw/rtl/mmpid_csr.sv
hw/rtl/multi_mode_pid_controller_top.sv
tb/tb_multi_mode_pid_controller_top.sv
